@@ design/snfd_pkg.sv @@
// shared types and constants for the serial nor flash device model
`default_nettype none
package snfd_pkg;

   // array geometry defaults
   localparam int FLASH_BYTES_DEF  = 65536;
   localparam int SECTOR_BYTES_DEF = 4096;
   localparam int PAGE_BYTES_DEF   = 256;

   // item queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = 1;

   // opcodes
   localparam logic [7:0] OP_WRSR  = 8'h01;
   localparam logic [7:0] OP_PROG  = 8'h02;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_WRDI  = 8'h04;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_SECT  = 8'h20;
   localparam logic [7:0] OP_CHIP1 = 8'h60;
   localparam logic [7:0] OP_MFID  = 8'h90;
   localparam logic [7:0] OP_JEDEC = 8'h9F;
   localparam logic [7:0] OP_CHIP2 = 8'hC7;

   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   // register indexes
   localparam logic [1:0] REG_MFR_ID   = 2'd0;
   localparam logic [1:0] REG_DEV_ID   = 2'd1;
   localparam logic [1:0] REG_MEM_TYPE = 2'd2;
   localparam logic [1:0] REG_CAP_CODE = 2'd3;

   // one queued item, already classified
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } item_type;

   // back to front control
   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_ctl_type;

   // identification registers
   typedef struct packed {
      logic [7:0] mfr_id;
      logic [7:0] dev_id;
      logic [7:0] mem_type;
      logic [7:0] cap_code;
   } id_regs_type;

endpackage
`default_nettype wire

@@ design/snfd_front.sv @@
// front end: accepts items, classifies them and queues them for the back end
`default_nettype none
module snfd_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    req_kind,
   input  wire  [7:0]             req_mosi_byte,
   input  snfd_pkg::back_ctl_type back_ctl,
   output logic                   q_valid,
   output snfd_pkg::item_type     q_item
);
   import snfd_pkg::*;

   item_type                 ent_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [QUEUE_PW:0]        cnt_ff, cnt_in;
   logic                     push, pop;

   // no items while the array is being cleared after reset
   assign req_ready = (cnt_ff != (QUEUE_PW+1)'(QUEUE_DEPTH)) && !back_ctl.init_busy;
   assign push      = req_valid && req_ready;
   assign pop       = back_ctl.pop && q_valid;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = ent_ff[rp_ff];

   // pointer and fill count
   always_comb begin
      wp_in  = push ? QUEUE_PW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? QUEUE_PW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = (QUEUE_PW+1)'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = (QUEUE_PW+1)'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage, frame end flagged at entry
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff].is_end <= req_kind;
         ent_ff[wp_ff].data   <= req_mosi_byte;
      end
   end

endmodule
`default_nettype wire

@@ design/snfd_back.sv @@
// back end: command decode, flash array, erase sweeps and result register
`default_nettype none
module snfd_back #(
   parameter int FLASH_BYTES  = snfd_pkg::FLASH_BYTES_DEF,
   parameter int SECTOR_BYTES = snfd_pkg::SECTOR_BYTES_DEF,
   parameter int PAGE_BYTES   = snfd_pkg::PAGE_BYTES_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_valid,
   input  snfd_pkg::item_type     q_item,
   output snfd_pkg::back_ctl_type back_ctl,
   input  snfd_pkg::id_regs_type  id_regs,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [7:0]             rsp_miso_byte
);
   import snfd_pkg::*;

   localparam int AW = $clog2(FLASH_BYTES);
   localparam int PW = $clog2(PAGE_BYTES);
   localparam logic [AW-1:0] SMASK =
      (SECTOR_BYTES >= FLASH_BYTES) ? {AW{1'b1}} : AW'(SECTOR_BYTES - 1);

   localparam logic [1:0] S_SWEEP = 2'd0;
   localparam logic [1:0] S_TAKE  = 2'd1;
   localparam logic [1:0] S_MEM   = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [7:0]    op_ff, op_in;
   logic [2:0]    idx_ff, idx_in;
   logic [23:0]   addr_ff, addr_in;
   logic          wel_ff, wel_in;
   logic [5:0]    prot_ff, prot_in;
   logic          armed_ff, armed_in;
   logic          init_ff, init_in;
   logic [AW-1:0] ctr_ff, ctr_in;
   logic [AW-1:0] mask_ff, mask_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [7:0]    data_ff, data_in;
   logic          rv_ff, rv_in;
   logic [7:0]    rb_ff, rb_in;

   logic [7:0]    mem [FLASH_BYTES];
   logic [7:0]    rdata_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic [AW-1:0] a;
   logic          slot_free, take, addressed;
   logic [7:0]    b;

   assign a         = addr_ff[AW-1:0];
   assign b         = q_item.data;
   assign slot_free = !rv_ff || rsp_ready;
   assign take      = (state_ff == S_TAKE) && q_valid && slot_free;
   assign addressed = (op_ff == OP_READ) || (op_ff == OP_PROG) ||
                      (op_ff == OP_SECT) || (op_ff == OP_MFID);

   assign back_ctl.pop       = take;
   assign back_ctl.init_busy = init_ff;
   assign rsp_valid          = rv_ff;
   assign rsp_miso_byte      = rb_ff;

   // command sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      wel_in   = wel_ff;
      prot_in  = prot_ff;
      armed_in = armed_ff;
      init_in  = init_ff;
      ctr_in   = ctr_ff;
      mask_in  = mask_ff;
      wa_in    = wa_ff;
      data_in  = data_ff;
      rv_in    = rv_ff && !rsp_ready;
      rb_in    = rb_ff;
      we       = 1'b0;
      waddr    = ctr_ff;
      wdata    = IDLE_BYTE;
      unique case (state_ff)
         S_SWEEP: begin
            we = 1'b1;
            if ((ctr_ff & mask_ff) == mask_ff) begin
               state_in = S_TAKE;
               init_in  = 1'b0;
            end else begin
               ctr_in = AW'(ctr_ff + 1'b1);
            end
         end
         S_TAKE: begin
            if (take) begin
               rv_in = 1'b1;
               rb_in = IDLE_BYTE;
               if (q_item.is_end) begin
                  // frame end: latch updates and erase commits
                  if (idx_ff != 3'd0) begin
                     if (op_ff == OP_WREN) begin
                        wel_in = 1'b1;
                     end else if (op_ff == OP_WRDI) begin
                        wel_in = 1'b0;
                     end else if (op_ff == OP_SECT) begin
                        if (wel_ff && idx_ff == 3'd4) begin
                           ctr_in   = a & ~SMASK;
                           mask_in  = SMASK;
                           state_in = S_SWEEP;
                        end
                        wel_in = 1'b0;
                     end else if (op_ff == OP_CHIP1 || op_ff == OP_CHIP2) begin
                        if (wel_ff && idx_ff == 3'd1) begin
                           ctr_in   = '0;
                           mask_in  = {AW{1'b1}};
                           state_in = S_SWEEP;
                        end
                        wel_in = 1'b0;
                     end else if (op_ff == OP_PROG || op_ff == OP_WRSR) begin
                        wel_in = 1'b0;
                     end
                  end
                  op_in    = '0;
                  idx_in   = '0;
                  addr_in  = '0;
                  armed_in = 1'b0;
               end else begin
                  // byte exchanged
                  if (idx_ff == 3'd0) begin
                     op_in    = b;
                     armed_in = (b == OP_PROG) && wel_ff;
                  end else if (addressed && idx_ff <= 3'd3) begin
                     addr_in = {addr_ff[15:0], b};
                     if (idx_ff == 3'd3) begin
                        addr_in = 24'({addr_ff[15:0], b} & 24'((FLASH_BYTES - 1)));
                     end
                  end else if (op_ff == OP_READ) begin
                     // result comes from the registered array read
                     rv_in    = 1'b0;
                     state_in = S_MEM;
                     addr_in  = 24'(AW'(a + 1'b1));
                  end else if (op_ff == OP_PROG) begin
                     if (armed_ff) begin
                        state_in = S_MEM;
                        wa_in    = a;
                        data_in  = b;
                     end
                     addr_in = 24'({a[AW-1:PW], PW'(a[PW-1:0] + 1'b1)});
                  end else if (op_ff == OP_MFID) begin
                     rb_in   = addr_ff[0] ? id_regs.dev_id : id_regs.mfr_id;
                     addr_in = 24'(addr_ff + 1'b1);
                  end else if (op_ff == OP_RDSR) begin
                     rb_in = {prot_ff, wel_ff, 1'b0};
                  end else if (op_ff == OP_WRSR) begin
                     if (idx_ff == 3'd1 && wel_ff) begin
                        prot_in = b[7:2];
                     end
                  end else if (op_ff == OP_JEDEC) begin
                     if (idx_ff == 3'd1) begin
                        rb_in = id_regs.mfr_id;
                     end else if (idx_ff == 3'd2) begin
                        rb_in = id_regs.mem_type;
                     end else if (idx_ff == 3'd3) begin
                        rb_in = id_regs.cap_code;
                     end
                  end
                  if (idx_ff != 3'd7) begin
                     idx_in = 3'(idx_ff + 1'b1);
                  end
               end
            end
         end
         S_MEM: begin
            state_in = S_TAKE;
            if (op_ff == OP_READ) begin
               rv_in = 1'b1;
               rb_in = rdata_ff;
            end else begin
               we    = 1'b1;
               waddr = wa_ff;
               wdata = rdata_ff & data_ff;
            end
         end
         default: begin
            state_in = S_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         op_ff    <= '0;
         idx_ff   <= '0;
         addr_ff  <= '0;
         wel_ff   <= 1'b0;
         prot_ff  <= '0;
         armed_ff <= 1'b0;
         init_ff  <= 1'b1;
         ctr_ff   <= '0;
         mask_ff  <= {AW{1'b1}};
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         addr_ff  <= addr_in;
         wel_ff   <= wel_in;
         prot_ff  <= prot_in;
         armed_ff <= armed_in;
         init_ff  <= init_in;
         ctr_ff   <= ctr_in;
         mask_ff  <= mask_in;
         rv_ff    <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      data_ff <= data_in;
      rb_ff   <= rb_in;
   end

   // flash array, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[a];
   end

endmodule
`default_nettype wire

@@ design/spi_nor_flash_device_model_top.sv @@
// top level of the serial nor flash device model with its register port
// path: queue entry, then result register; read data goes through rdata_ff first
// one item per cycle absent backpressure; reads and armed programs add an S_MEM step
// sector erase stalls the back end for a sector sweep, chip erase for a full sweep
// reset: array cleared by a full sweep during which req_ready stays low
// FLASH_BYTES, SECTOR_BYTES and PAGE_BYTES are powers of two
`default_nettype none
module spi_nor_flash_device_model_top #(
   parameter int FLASH_BYTES  = snfd_pkg::FLASH_BYTES_DEF,
   parameter int SECTOR_BYTES = snfd_pkg::SECTOR_BYTES_DEF,
   parameter int PAGE_BYTES   = snfd_pkg::PAGE_BYTES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_kind,
   input  wire  [7:0]  req_mosi_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_miso_byte,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [3:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import snfd_pkg::*;

   id_regs_type  id_ff;
   back_ctl_type back_ctl;
   item_type     q_item;
   logic         q_valid;
   logic [1:0]   ridx;

   assign pready = 1'b1;
   assign ridx   = paddr[3:2];

   // identification registers
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff.mfr_id   <= 8'hEF;
         id_ff.dev_id   <= 8'h13;
         id_ff.mem_type <= 8'h40;
         id_ff.cap_code <= 8'h14;
      end else if (psel && penable && pwrite) begin
         unique case (ridx)
            REG_MFR_ID:   id_ff.mfr_id   <= pwdata[7:0];
            REG_DEV_ID:   id_ff.dev_id   <= pwdata[7:0];
            REG_MEM_TYPE: id_ff.mem_type <= pwdata[7:0];
            REG_CAP_CODE: id_ff.cap_code <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (ridx)
         REG_MFR_ID:   prdata = {24'd0, id_ff.mfr_id};
         REG_DEV_ID:   prdata = {24'd0, id_ff.dev_id};
         REG_MEM_TYPE: prdata = {24'd0, id_ff.mem_type};
         REG_CAP_CODE: prdata = {24'd0, id_ff.cap_code};
         default:      prdata = '0;
      endcase
   end

   snfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_mosi_byte (req_mosi_byte),
      .back_ctl      (back_ctl),
      .q_valid       (q_valid),
      .q_item        (q_item)
   );

   snfd_back #(
      .FLASH_BYTES  (FLASH_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .back_ctl      (back_ctl),
      .id_regs       (id_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_miso_byte (rsp_miso_byte)
   );

endmodule
`default_nettype wire

@@ design/snfd_checker.sv @@
// port level checks for the device model, bound to the top level
`default_nettype none
module snfd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [7:0]  rsp_miso_byte,
   input wire        psel,
   input wire        penable,
   input wire        pwrite,
   input wire [3:0]  paddr,
   input wire [31:0] pwdata,
   input wire [31:0] prdata,
   input wire        pready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_miso_byte))
      else $error("result changed while stalled");

   // clearing pass blocks items right after reset
   a_init_block: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("item accepted during clearing pass");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

   // a written register reads back its low byte
   a_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready |=>
         (paddr != $past(paddr)) || (prdata[7:0] == $past(pwdata[7:0])))
      else $error("register read back mismatch");

endmodule

bind spi_nor_flash_device_model_top snfd_checker u_snfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_miso_byte (rsp_miso_byte),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata),
   .pready        (pready)
);
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the serial nor flash device model top level
`timescale 1ns / 1ps
module tb;
   import snfd_pkg::*;

   // item fields: kind then mosi byte
   typedef struct packed {
      logic       kind;
      logic [7:0] mosi;
   } spi_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_mosi_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_miso_byte;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   spi_nor_flash_device_model_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_mosi_byte(req_mosi_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_miso_byte(rsp_miso_byte),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // flash shadow state
   logic [7:0]  shadow_mem [0:FLASH_BYTES_DEF-1];
   logic [7:0]  sh_op;
   logic [2:0]  sh_idx;
   logic [23:0] sh_addr;
   logic        sh_wel;
   logic [5:0]  sh_prot;
   logic        sh_armed;
   logic [7:0]  id_mfr, id_dev, id_type, id_cap;

   spi_item_type pend_items[$];
   logic [7:0] miso_expected[$];
   int         pushed_n = 0;
   int         taken_n = 0;
   int         errors = 0;
   bit         quiet = 0;
   int         chip_budget = 4;
   int         sect_budget = 50;

   // erase the whole shadow array
   function automatic void shadow_chip_erase();
      for (int i = 0; i < FLASH_BYTES_DEF; i++) shadow_mem[i] = IDLE_BYTE;
   endfunction

   // predict the reply byte for one accepted item
   function automatic logic [7:0] predict_miso(spi_item_type it);
      logic [7:0] r;
      int a, off, base;
      bit addressed;
      r = IDLE_BYTE;
      if (it.kind) begin
         if (sh_idx != 0) begin
            if (sh_op == OP_WREN) sh_wel = 1'b1;
            else if (sh_op == OP_WRDI) sh_wel = 1'b0;
            else if (sh_op == OP_SECT) begin
               if (sh_wel && sh_idx == 3'd4) begin
                  base = (int'(sh_addr) % FLASH_BYTES_DEF) & ~(SECTOR_BYTES_DEF - 1);
                  for (int i = 0; i < SECTOR_BYTES_DEF; i++) shadow_mem[base + i] = IDLE_BYTE;
               end
               sh_wel = 1'b0;
            end else if (sh_op == OP_CHIP1 || sh_op == OP_CHIP2) begin
               if (sh_wel && sh_idx == 3'd1) shadow_chip_erase();
               sh_wel = 1'b0;
            end else if (sh_op == OP_PROG || sh_op == OP_WRSR) sh_wel = 1'b0;
         end
         sh_op = 8'h00;
         sh_idx = 3'd0;
         sh_addr = 24'd0;
         sh_armed = 1'b0;
      end else begin
         addressed = (sh_op == OP_READ || sh_op == OP_PROG || sh_op == OP_SECT ||
                      sh_op == OP_MFID);
         if (sh_idx == 0) begin
            sh_op = it.mosi;
            sh_armed = (it.mosi == OP_PROG) && sh_wel;
         end else if (addressed && sh_idx <= 3) begin
            sh_addr = {sh_addr[15:0], it.mosi};
            if (sh_idx == 3) sh_addr = 24'(int'(sh_addr) % FLASH_BYTES_DEF);
         end else if (sh_op == OP_READ) begin
            a = int'(sh_addr) % FLASH_BYTES_DEF;
            r = shadow_mem[a];
            sh_addr = 24'((a + 1) % FLASH_BYTES_DEF);
         end else if (sh_op == OP_PROG) begin
            a = int'(sh_addr) % FLASH_BYTES_DEF;
            off = a % PAGE_BYTES_DEF;
            if (sh_armed) shadow_mem[a] = shadow_mem[a] & it.mosi;
            sh_addr = 24'((a - off + (off + 1) % PAGE_BYTES_DEF) % FLASH_BYTES_DEF);
         end else if (sh_op == OP_MFID) begin
            r = sh_addr[0] ? id_dev : id_mfr;
            sh_addr = sh_addr + 24'd1;
         end else if (sh_op == OP_RDSR) begin
            r = {sh_prot, sh_wel, 1'b0};
         end else if (sh_op == OP_WRSR) begin
            if (sh_idx == 1 && sh_wel) sh_prot = it.mosi[7:2];
         end else if (sh_op == OP_JEDEC) begin
            if (sh_idx == 1) r = id_mfr;
            else if (sh_idx == 2) r = id_type;
            else if (sh_idx == 3) r = id_cap;
         end
         if (sh_idx < 3'd7) sh_idx = sh_idx + 3'd1;
      end
      return r;
   endfunction

   // request driver with random gaps
   int gap_cnt = 0;
   always @(posedge clock) begin
      spi_item_type nxt;
      logic      nv;
      bit        free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         free = !req_valid;
         if (req_valid && req_ready) begin
            miso_expected.push_back(predict_miso({req_kind, req_mosi_byte}));
            taken_n++;
            free = 1;
            if (!quiet && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 10);
         end
         if (free) begin
            nv = 1'b0;
            if (gap_cnt > 0) gap_cnt--;
            else if (pend_items.size() > 0) begin
               nxt = pend_items.pop_front();
               nv = 1'b1;
               req_kind <= nxt.kind;
               req_mosi_byte <= nxt.mosi;
            end
            req_valid <= nv;
         end
      end
   end

   // response monitor with random backpressure
   int rdy_cnt = 0;
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (miso_expected.size() == 0) begin
               $display("%0t: unexpected miso_byte expected none actual %h", $time,
                        rsp_miso_byte);
               errors++;
            end else begin
               want = miso_expected.pop_front();
               if (rsp_miso_byte !== want) begin
                  $display("%0t: miso_byte mismatch expected %h actual %h", $time,
                           want, rsp_miso_byte);
                  errors++;
               end
            end
         end
         if (rdy_cnt > 0) rdy_cnt--;
         else if (quiet || $urandom_range(0, 1) == 0) begin
            rsp_ready <= 1'b1;
            rdy_cnt = $urandom_range(1, 20);
         end else begin
            rsp_ready <= 1'b0;
            rdy_cnt = $urandom_range(0, 9);
         end
      end
   end

   // watchdog on lack of progress
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 400000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_item(logic kind, logic [7:0] b);
      pend_items.push_back({kind, b});
      pushed_n++;
   endtask

   task automatic push_end();
      push_item(1'b1, 8'($urandom));
   endtask

   // address mostly inside the first sector so reads meet programs
   task automatic push_addr(int page_tail);
      logic [7:0] mid, lo;
      mid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      lo = (page_tail != 0) ? 8'($urandom_range(240, 255)) : 8'($urandom);
      push_item(1'b0, 8'($urandom));
      push_item(1'b0, mid);
      push_item(1'b0, lo);
   endtask

   task automatic push_wren();
      push_item(1'b0, OP_WREN);
      push_end();
   endtask

   // one random frame, mostly well formed
   task automatic push_frame();
      int n;
      logic [7:0] op;
      case ($urandom_range(0, 13))
         0, 1, 2: begin
            push_item(1'b0, OP_READ); push_addr(0);
            n = $urandom_range(1, 12);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         3, 4, 5: begin
            if ($urandom_range(0, 4) != 0) push_wren();
            push_item(1'b0, OP_PROG); push_addr(int'($urandom_range(0, 2) == 0));
            n = $urandom_range(1, 20);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         6: begin
            if (sect_budget > 0) begin
               sect_budget--;
               if ($urandom_range(0, 3) != 0) push_wren();
               push_item(1'b0, OP_SECT);
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
               repeat (n) push_item(1'b0, ($urandom_range(0, 1)) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 7)));
            end else push_item(1'b0, OP_RDSR);
         end
         7: begin
            if ($urandom_range(0, 1)) push_wren();
            push_item(1'b0, OP_WRSR);
            n = $urandom_range(0, 3);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         8: begin
            push_item(1'b0, OP_RDSR);
            n = $urandom_range(0, 6);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         9: begin
            push_item(1'b0, $urandom_range(0, 1) ? OP_WRDI : OP_WREN);
            if ($urandom_range(0, 3) == 0) push_item(1'b0, 8'($urandom));
         end
         10: begin
            push_item(1'b0, OP_MFID);
            n = $urandom_range(0, 8);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         11: begin
            push_item(1'b0, OP_JEDEC);
            n = $urandom_range(0, 6);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         12: begin
            op = 8'($urandom);
            if (op == OP_SECT || op == OP_CHIP1 || op == OP_CHIP2) op = 8'hAB;
            n = $urandom_range(0, 5);
            push_item(1'b0, op);
            repeat (n) push_item(1'b0, 8'($urandom));
         end
         default: begin
            if (chip_budget > 0 && $urandom_range(0, 9) == 0) begin
               chip_budget--;
               if ($urandom_range(0, 2) != 0) push_wren();
               push_item(1'b0, $urandom_range(0, 1) ? OP_CHIP1 : OP_CHIP2);
               if ($urandom_range(0, 3) == 0) push_item(1'b0, 8'($urandom));
            end
         end
      endcase
      push_end();
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= {24'($urandom), val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_MFR_ID:   id_mfr = val;
         REG_DEV_ID:   id_dev = val;
         REG_MEM_TYPE: id_type = val;
         default:      id_cap = val;
      endcase
   endtask

   // wait until the block has drained, closing with a status read so any erase is over
   task automatic drain();
      push_item(1'b0, OP_RDSR); push_item(1'b0, 8'h00); push_end();
      while (taken_n != pushed_n || miso_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int target;
      shadow_chip_erase();
      sh_op = 8'h00; sh_idx = 3'd0; sh_addr = 24'd0; sh_wel = 1'b0;
      sh_prot = 6'd0; sh_armed = 1'b0;
      id_mfr = 8'hEF; id_dev = 8'h13; id_type = 8'h40; id_cap = 8'h14;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed frames on reset ids
      push_item(1'b0, OP_JEDEC); repeat (4) push_item(1'b0, 8'h00); push_end();
      push_item(1'b0, OP_MFID); push_item(1'b0, 8'h00); push_item(1'b0, 8'h00);
      push_item(1'b0, 8'h01); push_item(1'b0, 8'h00); push_item(1'b0, 8'h00); push_end();
      push_end();
      push_wren();
      push_item(1'b0, OP_PROG); push_item(1'b0, 8'hFF); push_item(1'b0, 8'hFF);
      push_item(1'b0, 8'hFF); push_item(1'b0, 8'h00); push_item(1'b0, 8'h5A); push_end();
      push_item(1'b0, OP_READ); push_item(1'b0, 8'h00); push_item(1'b0, 8'hFF);
      push_item(1'b0, 8'hFF); push_item(1'b0, 8'hFF); push_item(1'b0, 8'hFF); push_end();
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) quiet = 1;
         case (ph)
            0: begin csr_write(REG_MFR_ID, 8'h00); csr_write(REG_DEV_ID, 8'hFF);
                     csr_write(REG_MEM_TYPE, 8'h00); csr_write(REG_CAP_CODE, 8'hFF); end
            1: begin csr_write(REG_MFR_ID, 8'hFF); csr_write(REG_DEV_ID, 8'h00);
                     csr_write(REG_MEM_TYPE, 8'hFF); csr_write(REG_CAP_CODE, 8'h00); end
            default: begin
               csr_write(REG_MFR_ID, 8'($urandom)); csr_write(REG_DEV_ID, 8'($urandom));
               csr_write(REG_MEM_TYPE, 8'($urandom)); csr_write(REG_CAP_CODE, 8'($urandom));
            end
         endcase
         target = pushed_n + 220;
         while (pushed_n < target) push_frame();
         drain();
      end

      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
